// ===== rtl/mt_pkg.sv =====
// Package with payload types and constants for the MT19937 generator.
`timescale 1ns / 1ps
`default_nettype none
package mt_pkg;
    localparam int unsigned StateDepth = 624;
    localparam int unsigned TwistOffset = 397;
    localparam logic [31:0] SeedMult = 32'd1812433253;
    localparam logic [31:0] TwistMatrix = 32'h9908b0df;
    localparam logic [31:0] UpperMask = 32'h80000000;
    localparam logic [31:0] LowerMask = 32'h7fffffff;
    localparam logic [31:0] TemperB = 32'h9d2c5680;
    localparam logic [31:0] TemperC = 32'hefc60000;
    localparam logic [31:0] DefaultSeed = 32'd5489;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_RAW = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] seed_value;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } mt_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        range_empty;
    } mt_rsp_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mt_divider.sv =====
// Restoring divider: 32-bit remainder, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mt_divider
    import mt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    // One shift-and-subtract step
    always_comb begin
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[30:0], 1'b0};
            rem_next = trial[32] ? shifted[31:0] : trial[31:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/mersenne_twister_prng_top.sv =====
// Top level of the MT19937 generator: state memory, sequencer and result register.
// Raw word: read from state memory, tempered, then registered as result; the first word after a seed,
// and the first after every 624 words, adds a twist (three reads and one write per state word).
// Ranged word adds a pass through the remainder divider; a zero span answers straight from idle.
// Reseed writes the state words one by one, alternating ST_SEED (write) with ST_SEEDM (next word).
// After aresetn the block seeds itself with 5489, with s_ready low until the seed is done.
`timescale 1ns / 1ps
`default_nettype none
module mersenne_twister_prng_top
    import mt_pkg::*;
#(
    parameter int STATE_DEPTH = 624
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire mt_req_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output mt_rsp_t      m_data
);
    localparam int IW = $clog2(STATE_DEPTH + 1);
    localparam int AW = $clog2(STATE_DEPTH);
    localparam logic [IW-1:0] DEPTH_I = IW'(STATE_DEPTH);
    localparam logic [AW-1:0] LAST_A = AW'(STATE_DEPTH - 1);
    localparam logic [AW-1:0] OFF_A = AW'(TwistOffset);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SEED = 4'd1;
    localparam logic [3:0] ST_TW_R0 = 4'd2;
    localparam logic [3:0] ST_TW_R1 = 4'd3;
    localparam logic [3:0] ST_TW_R2 = 4'd4;
    localparam logic [3:0] ST_TW_W = 4'd5;
    localparam logic [3:0] ST_RD = 4'd6;
    localparam logic [3:0] ST_RDW = 4'd7;
    localparam logic [3:0] ST_TEMP = 4'd8;
    localparam logic [3:0] ST_DIV = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;
    localparam logic [3:0] ST_SEEDM = 4'd11;
    localparam logic [3:0] ST_DIVGO = 4'd12;

    logic [31:0] mem [STATE_DEPTH];
    logic [31:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // Synchronous state memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    logic [3:0]    st_reg, st_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [31:0]   prev_reg, prev_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [31:0]   w_reg, w_next;
    mt_req_t       req_reg, req_next;
    logic          mv_reg, mv_next;
    mt_rsp_t       out_reg, out_next;
    logic          div_start;
    logic          div_done;
    logic [31:0]   div_rem;
    logic [31:0]   span;
    logic [31:0]   y;
    logic [31:0]   seed_word;
    logic [AW-1:0] ptr_inc;
    logic [AW-1:0] ptr_far;
    logic [AW:0]   far_sum;

    assign span    = req_reg.range_high - req_reg.range_low;
    assign ptr_inc = (ptr_reg == LAST_A) ? '0 : ptr_reg + AW'(1);
    assign far_sum = {1'b0, ptr_reg} + {1'b0, OFF_A};
    assign ptr_far = (far_sum >= (AW+1)'(STATE_DEPTH)) ?
                     AW'(far_sum - (AW+1)'(STATE_DEPTH)) : far_sum[AW-1:0];
    assign y       = (a_reg & UpperMask) | (b_reg & LowerMask);
    assign seed_word = prev_reg ^ (prev_reg >> 30);

    mt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (w_reg),
        .divisor  (span),
        .done     (div_done),
        .remainder(div_rem)
    );

    assign s_ready = (st_reg == ST_IDLE) && !mv_reg;

    // Sequencer
    always_comb begin
        st_next   = st_reg;
        idx_next  = idx_reg;
        ptr_next  = ptr_reg;
        prev_next = prev_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        w_next    = w_reg;
        req_next  = req_reg;
        mv_next   = mv_reg;
        out_next  = out_reg;
        rd_addr   = ptr_reg;
        we        = 1'b0;
        wr_addr   = ptr_reg;
        wr_data   = prev_reg;
        div_start = 1'b0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next = s_data;
                    case (s_data.opcode)
                        OP_RESEED: begin
                            prev_next = s_data.seed_value;
                            ptr_next  = '0;
                            st_next   = ST_SEED;
                        end
                        OP_RAW: begin
                            st_next = (idx_reg >= DEPTH_I) ? ST_TW_R0 : ST_RD;
                            ptr_next = (idx_reg >= DEPTH_I) ? '0 : idx_reg[AW-1:0];
                        end
                        OP_RANGE: begin
                            if (s_data.range_high == s_data.range_low) begin
                                out_next.value       = s_data.range_low;
                                out_next.range_empty = 1'b1;
                                mv_next              = 1'b1;
                            end else begin
                                st_next = (idx_reg >= DEPTH_I) ? ST_TW_R0 : ST_RD;
                                ptr_next = (idx_reg >= DEPTH_I) ? '0 : idx_reg[AW-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Write one seed word, then form the next one
            ST_SEED: begin
                we      = 1'b1;
                st_next = ST_SEEDM;
                if (ptr_reg == LAST_A) begin
                    idx_next = DEPTH_I;
                    st_next  = ST_IDLE;
                end
            end
            ST_SEEDM: begin
                ptr_next  = ptr_inc;
                prev_next = SeedMult * seed_word + 32'(ptr_inc);
                st_next   = ST_SEED;
            end
            // Twist: read word i, then i+1, then i+397, write i
            ST_TW_R0: begin
                rd_addr = ptr_reg;
                st_next = ST_TW_R1;
            end
            ST_TW_R1: begin
                a_next  = rd_data;
                rd_addr = ptr_inc;
                st_next = ST_TW_R2;
            end
            ST_TW_R2: begin
                b_next  = rd_data;
                rd_addr = ptr_far;
                st_next = ST_TW_W;
            end
            ST_TW_W: begin
                we       = 1'b1;
                wr_data  = rd_data ^ (y >> 1) ^ (y[0] ? TwistMatrix : 32'd0);
                st_next  = (ptr_reg == LAST_A) ? ST_RD : ST_TW_R0;
                ptr_next = ptr_inc;
                if (ptr_reg == LAST_A) begin
                    idx_next = '0;
                end
            end
            ST_RD: begin
                rd_addr = idx_reg[AW-1:0];
                st_next = ST_RDW;
            end
            ST_RDW: begin
                rd_addr  = idx_reg[AW-1:0];
                idx_next = idx_reg + IW'(1);
                st_next  = ST_TEMP;
            end
            ST_TEMP: begin
                w_next = temper(rd_data);
                if (req_reg.opcode == OP_RANGE) begin
                    st_next = ST_DIVGO;
                end else begin
                    out_next.value       = temper(rd_data);
                    out_next.range_empty = 1'b0;
                    st_next              = ST_OUT;
                end
            end
            // Launch the remainder, then wait for it
            ST_DIVGO: begin
                div_start = 1'b1;
                st_next   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    out_next.value       = req_reg.range_low + div_rem;
                    out_next.range_empty = 1'b0;
                    st_next              = ST_OUT;
                end
            end
            ST_OUT: begin
                mv_next = 1'b1;
                st_next = ST_IDLE;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_SEED;
            idx_reg  <= DEPTH_I;
            ptr_reg  <= '0;
            prev_reg <= DefaultSeed;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            idx_reg  <= idx_next;
            ptr_reg  <= ptr_next;
            prev_reg <= prev_next;
            mv_reg   <= mv_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        w_reg   <= w_next;
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire
